// ===== hdl/wasmxu_pkg.sv =====
// wasmxu_pkg: constants, opcodes, status codes, state and interface types
// shared by the stack execute unit and its divider; no dependencies
`timescale 1ns / 1ps
package wasmxu_pkg;

	localparam int STACK_DEPTH  = 64;
	localparam int SP_W         = $clog2(STACK_DEPTH + 1);
	localparam int SA_W         = $clog2(STACK_DEPTH);
	localparam int NUM_LOCALS   = 16;
	localparam int LV_W         = $clog2(NUM_LOCALS);
	localparam int GLOBAL_COUNT = 16;
	localparam int GV_W         = $clog2(GLOBAL_COUNT);
	localparam int MEM_BYTES    = 65536;
	localparam int MA_W         = $clog2(MEM_BYTES);
	localparam int CFG_W        = 17;

	localparam logic [7:0] OP_TRAP        = 8'h00;
	localparam logic [7:0] OP_NOP         = 8'h01;
	localparam logic [7:0] OP_DROP        = 8'h1A;
	localparam logic [7:0] OP_SEL         = 8'h1B;
	localparam logic [7:0] OP_LGET        = 8'h20;
	localparam logic [7:0] OP_LSET        = 8'h21;
	localparam logic [7:0] OP_LTEE        = 8'h22;
	localparam logic [7:0] OP_GGET        = 8'h23;
	localparam logic [7:0] OP_GSET        = 8'h24;
	localparam logic [7:0] OP_LOAD        = 8'h28;
	localparam logic [7:0] OP_LOAD8_S     = 8'h2C;
	localparam logic [7:0] OP_LOAD8_U     = 8'h2D;
	localparam logic [7:0] OP_LOAD16_S    = 8'h2E;
	localparam logic [7:0] OP_LOAD16_U    = 8'h2F;
	localparam logic [7:0] OP_STORE       = 8'h36;
	localparam logic [7:0] OP_STORE8      = 8'h3A;
	localparam logic [7:0] OP_STORE16     = 8'h3B;
	localparam logic [7:0] OP_CONST       = 8'h41;
	localparam logic [7:0] OP_EQZ         = 8'h45;
	localparam logic [7:0] OP_EQ          = 8'h46;
	localparam logic [7:0] OP_NE          = 8'h47;
	localparam logic [7:0] OP_LT_S        = 8'h48;
	localparam logic [7:0] OP_LT_U        = 8'h49;
	localparam logic [7:0] OP_GT_S        = 8'h4A;
	localparam logic [7:0] OP_GT_U        = 8'h4B;
	localparam logic [7:0] OP_LE_S        = 8'h4C;
	localparam logic [7:0] OP_LE_U        = 8'h4D;
	localparam logic [7:0] OP_GE_S        = 8'h4E;
	localparam logic [7:0] OP_GE_U        = 8'h4F;
	localparam logic [7:0] OP_ADD         = 8'h6A;
	localparam logic [7:0] OP_SUB         = 8'h6B;
	localparam logic [7:0] OP_MUL         = 8'h6C;
	localparam logic [7:0] OP_DIV_S       = 8'h6D;
	localparam logic [7:0] OP_DIV_U       = 8'h6E;
	localparam logic [7:0] OP_REM_S       = 8'h6F;
	localparam logic [7:0] OP_REM_U       = 8'h70;
	localparam logic [7:0] OP_AND         = 8'h71;
	localparam logic [7:0] OP_OR          = 8'h72;
	localparam logic [7:0] OP_XOR         = 8'h73;
	localparam logic [7:0] OP_SHL         = 8'h74;
	localparam logic [7:0] OP_SHR_S       = 8'h75;
	localparam logic [7:0] OP_SHR_U       = 8'h76;

	typedef enum logic [2:0] {
		TRAP_OK          = 3'd0,
		TRAP_UNREACHABLE = 3'd1,
		TRAP_BAD_OP      = 3'd2,
		TRAP_OVERFLOW    = 3'd3,
		TRAP_UNDERFLOW   = 3'd4,
		TRAP_DIV_ZERO    = 3'd5,
		TRAP_OOB         = 3'd6
	} trap_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_POP, S_POPW, S_EXEC, S_DIVW, S_PUSH, S_TEER, S_TEEW,
		S_LDR, S_LDW, S_LDX, S_STW, S_TOPR, S_TOPW
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

// ===== hdl/wasmxu_div.sv =====
// wasmxu_div: 32-bit unsigned restoring divider, one quotient bit per cycle
// depends on wasmxu_pkg for the request and response structs
`timescale 1ns / 1ps
module wasmxu_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wasmxu_pkg::div_req_t req,
	output wasmxu_pkg::div_rsp_t rsp
);
	import wasmxu_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] shift;
	logic [32:0] diff;

	assign shift = {rem_q, quo_q[31]};
	assign diff  = shift - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				if (!diff[32]) begin
					rem_q <= diff[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= shift[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== hdl/wasm_i32_stack_execute_unit.sv =====
// wasm_i32_stack_execute_unit: top level, sequencer over the operand stack ram
// and the linear memory ram; depends on wasmxu_pkg and wasmxu_div
`timescale 1ns / 1ps
// One decoded instruction is taken at a time and yields one result item
// holding status, top of stack and stack depth. The stack and linear memory
// are synchronous rams with a registered read, so each pop takes a pop state
// and a wait state for the read data; a load reads each byte in a read and a
// wait state and then extends the loaded value, a store writes one byte at a
// time, a tee reads the top of stack before it writes the local, and an item
// that meets a pending trap goes straight to the top-of-stack read. Division
// and remainder wait on the bit-serial divider. A trap is sticky until an
// item with start_frame set. The input is not taken while an item is in work;
// a finished result waits in the output register while the next item runs,
// and that item stalls before its own result until the register drains.
module wasm_i32_stack_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // op [7:0], imm [39:8]
	input  logic        s_axis_tuser,   // start_frame
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // status [2:0], top_value [34:3], stack_count [41:35]
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata
);
	import wasmxu_pkg::*;

	state_t      state_q, state_d;
	trap_t       trap_q;
	logic [CFG_W-1:0] cfg_q;
	logic [7:0]  op_q;
	logic [31:0] imm_q;
	logic [SP_W-1:0] sp_q;
	logic [SP_W-1:0] sp_m1;
	logic [1:0]  cnt_q;
	logic [1:0]  k_q;
	logic [31:0] p_q [3];
	logic [31:0] res_q;
	logic [31:0] val_q;
	logic [MA_W-1:0] addr_q;
	logic        neg_q;
	logic        rsel_q;
	logic [31:0] locals_q [NUM_LOCALS];
	logic [31:0] globals_q [GLOBAL_COUNT];
	logic        m_valid_q;
	logic [47:0] m_data_q;

	logic [31:0] stack_mem [STACK_DEPTH];
	logic [31:0] st_rdata;
	logic        st_we;
	logic [SA_W-1:0] st_waddr;
	logic [7:0]  lin_mem [MEM_BYTES];
	logic [7:0]  lm_rdata;
	logic        lm_we;
	logic [MA_W-1:0] lm_addr;

	div_req_t    dreq;
	div_rsp_t    drsp;

	logic accept;
	logic is_unr, is_nop, is_drop, is_sel, is_lget, is_lset, is_ltee, is_gget, is_gset;
	logic is_load, is_store, is_const, is_eqz, is_cmp, is_arith, is_div, is_bad;
	logic [1:0]  npop;
	logic [1:0]  wlast;
	logic        lidx_ok, gidx_ok, push_op, oob;
	logic [31:0] a_op, b_op, exec_res, arith_res, base;
	logic [33:0] end_addr;
	logic [CFG_W-1:0] lim;
	logic        cmp_res, lt_s;
	logic [4:0]  sh;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign sp_m1         = sp_q - SP_W'(1);

	// decode
	always_comb begin
		is_unr   = (op_q == OP_TRAP);
		is_nop   = (op_q == OP_NOP);
		is_drop  = (op_q == OP_DROP);
		is_sel   = (op_q == OP_SEL);
		is_lget  = (op_q == OP_LGET);
		is_lset  = (op_q == OP_LSET);
		is_ltee  = (op_q == OP_LTEE);
		is_gget  = (op_q == OP_GGET);
		is_gset  = (op_q == OP_GSET);
		is_load  = (op_q == OP_LOAD) || (op_q >= OP_LOAD8_S && op_q <= OP_LOAD16_U);
		is_store = (op_q == OP_STORE) || (op_q == OP_STORE8) || (op_q == OP_STORE16);
		is_const = (op_q == OP_CONST);
		is_eqz   = (op_q == OP_EQZ);
		is_cmp   = (op_q >= OP_EQ) && (op_q <= OP_GE_U);
		is_arith = (op_q >= OP_ADD) && (op_q <= OP_SHR_U);
		is_div   = (op_q >= OP_DIV_S) && (op_q <= OP_REM_U);
		is_bad   = !(is_unr || is_nop || is_drop || is_sel || is_lget || is_lset ||
			is_ltee || is_gget || is_gset || is_load || is_store || is_const ||
			is_eqz || is_cmp || is_arith);
		if (is_sel)
			npop = 2'd3;
		else if (is_store || is_cmp || is_arith)
			npop = 2'd2;
		else if (is_drop || is_lset || is_gset || is_load || is_eqz)
			npop = 2'd1;
		else
			npop = 2'd0;
		if (op_q == OP_LOAD || op_q == OP_STORE)
			wlast = 2'd3;
		else if (op_q == OP_LOAD8_S || op_q == OP_LOAD8_U || op_q == OP_STORE8)
			wlast = 2'd0;
		else
			wlast = 2'd1;
		lidx_ok = (imm_q[31:LV_W] == '0);
		gidx_ok = (imm_q[31:GV_W] == '0);
		push_op = is_sel || (is_lget && lidx_ok) || (is_gget && gidx_ok) || is_const ||
			is_eqz || is_cmp || (is_arith && !is_div);
	end

	// operands: b is the first pop, a the second
	assign b_op = p_q[0];
	assign a_op = p_q[1];
	assign sh   = b_op[4:0];
	assign lt_s = $signed(a_op) < $signed(b_op);

	always_comb begin
		case (op_q)
			OP_EQ:   cmp_res = (a_op == b_op);
			OP_NE:   cmp_res = (a_op != b_op);
			OP_LT_S: cmp_res = lt_s;
			OP_LT_U: cmp_res = (a_op < b_op);
			OP_GT_S: cmp_res = $signed(b_op) < $signed(a_op);
			OP_GT_U: cmp_res = (a_op > b_op);
			OP_LE_S: cmp_res = !($signed(b_op) < $signed(a_op));
			OP_LE_U: cmp_res = (a_op <= b_op);
			OP_GE_S: cmp_res = !lt_s;
			default: cmp_res = (a_op >= b_op);
		endcase
		case (op_q)
			OP_ADD:   arith_res = a_op + b_op;
			OP_SUB:   arith_res = a_op - b_op;
			OP_MUL:   arith_res = a_op * b_op;
			OP_AND:   arith_res = a_op & b_op;
			OP_OR:    arith_res = a_op | b_op;
			OP_XOR:   arith_res = a_op ^ b_op;
			OP_SHL:   arith_res = a_op << sh;
			OP_SHR_S: arith_res = 32'($signed(a_op) >>> sh);
			default:  arith_res = a_op >> sh;
		endcase
		if (is_sel)
			exec_res = (p_q[0] != 32'd0) ? p_q[2] : p_q[1];
		else if (is_lget)
			exec_res = locals_q[imm_q[LV_W-1:0]];
		else if (is_gget)
			exec_res = globals_q[imm_q[GV_W-1:0]];
		else if (is_const)
			exec_res = imm_q;
		else if (is_eqz)
			exec_res = {31'd0, (p_q[0] == 32'd0)};
		else if (is_cmp)
			exec_res = {31'd0, cmp_res};
		else
			exec_res = arith_res;
	end

	// bounds on the full sum, no wrap
	assign base     = is_store ? p_q[1] : p_q[0];
	assign lim      = (cfg_q > CFG_W'(MEM_BYTES)) ? CFG_W'(MEM_BYTES) : cfg_q;
	assign end_addr = {2'b0, base} + {2'b0, imm_q} + {32'd0, wlast} + 34'd1;
	assign oob      = end_addr > {{(34 - CFG_W){1'b0}}, lim};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_DEC;
			S_DEC: begin
				if (trap_q != TRAP_OK)
					state_d = S_TOPR;
				else if (npop != 2'd0)
					state_d = S_POP;
				else
					state_d = S_EXEC;
			end
			S_POP:  state_d = (sp_q == '0) ? S_TOPR : S_POPW;
			S_POPW: state_d = (cnt_q + 2'd1 == npop) ? S_EXEC : S_POP;
			S_EXEC: begin
				if (is_div)
					state_d = (b_op == 32'd0) ? S_TOPR : S_DIVW;
				else if (is_ltee)
					state_d = S_TEER;
				else if (is_load)
					state_d = oob ? S_TOPR : S_LDR;
				else if (is_store)
					state_d = oob ? S_TOPR : S_STW;
				else if (push_op)
					state_d = S_PUSH;
				else
					state_d = S_TOPR;
			end
			S_DIVW: if (drsp.done) state_d = S_PUSH;
			S_PUSH: state_d = S_TOPR;
			S_TEER: state_d = (sp_q == '0) ? S_TOPR : S_TEEW;
			S_TEEW: state_d = S_TOPR;
			S_LDR:  state_d = S_LDW;
			S_LDW:  state_d = (k_q == wlast) ? S_LDX : S_LDR;
			S_LDX:  state_d = S_PUSH;
			S_STW:  if (k_q == wlast) state_d = S_TOPR;
			S_TOPR: state_d = S_TOPW;
			S_TOPW: if (!m_valid_q || m_axis_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory and divider controls
	always_comb begin
		st_we    = (state_q == S_PUSH) && (sp_q < SP_W'(STACK_DEPTH));
		st_waddr = sp_q[SA_W-1:0];
		lm_we    = (state_q == S_STW);
		lm_addr  = addr_q + MA_W'(k_q);
		dreq.start    = (state_q == S_EXEC) && is_div && (b_op != 32'd0);
		dreq.dividend = ((op_q == OP_DIV_S || op_q == OP_REM_S) && a_op[31]) ? -a_op : a_op;
		dreq.divisor  = ((op_q == OP_DIV_S || op_q == OP_REM_S) && b_op[31]) ? -b_op : b_op;
	end

	always_ff @(posedge clk) begin
		if (st_we)
			stack_mem[st_waddr] <= res_q;
	end

	always_ff @(posedge clk) begin
		st_rdata <= stack_mem[sp_m1[SA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (lm_we)
			lin_mem[lm_addr] <= p_q[0][8*k_q +: 8];
	end

	always_ff @(posedge clk) begin
		lm_rdata <= lin_mem[lm_addr];
	end

	wasmxu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			trap_q    <= TRAP_OK;
			cfg_q     <= CFG_W'(MEM_BYTES);
			op_q      <= '0;
			imm_q     <= '0;
			sp_q      <= '0;
			cnt_q     <= '0;
			k_q       <= '0;
			p_q       <= '{default: '0};
			res_q     <= '0;
			val_q     <= '0;
			addr_q    <= '0;
			neg_q     <= 1'b0;
			rsel_q    <= 1'b0;
			locals_q  <= '{default: '0};
			globals_q <= '{default: '0};
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				cfg_q <= cfg_wdata;
			if (m_axis_tready && state_q != S_TOPW)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= s_axis_tdata[7:0];
						imm_q <= s_axis_tdata[39:8];
						if (s_axis_tuser) begin
							sp_q     <= '0;
							locals_q <= '{default: '0};
							trap_q   <= TRAP_OK;
						end
					end
				end
				S_DEC: cnt_q <= '0;
				S_POP: begin
					if (sp_q == '0)
						trap_q <= TRAP_UNDERFLOW;
					else
						sp_q <= sp_m1;
				end
				S_POPW: begin
					p_q[cnt_q] <= st_rdata;
					cnt_q      <= cnt_q + 2'd1;
				end
				S_EXEC: begin
					res_q  <= exec_res;
					k_q    <= '0;
					val_q  <= '0;
					addr_q <= MA_W'(base + imm_q);
					neg_q  <= (op_q == OP_DIV_S) ? (a_op[31] ^ b_op[31]) :
						(op_q == OP_REM_S) ? a_op[31] : 1'b0;
					rsel_q <= (op_q == OP_REM_S) || (op_q == OP_REM_U);
					if (is_unr)
						trap_q <= TRAP_UNREACHABLE;
					else if (is_bad)
						trap_q <= TRAP_BAD_OP;
					else if (is_div && b_op == 32'd0)
						trap_q <= TRAP_DIV_ZERO;
					else if ((is_load || is_store) && oob)
						trap_q <= TRAP_OOB;
					if (is_lset && lidx_ok)
						locals_q[imm_q[LV_W-1:0]] <= p_q[0];
					if (is_gset && gidx_ok)
						globals_q[imm_q[GV_W-1:0]] <= p_q[0];
				end
				S_DIVW: begin
					if (drsp.done) begin
						if (neg_q)
							res_q <= rsel_q ? -drsp.rem : -drsp.quo;
						else
							res_q <= rsel_q ? drsp.rem : drsp.quo;
					end
				end
				S_PUSH: begin
					if (sp_q < SP_W'(STACK_DEPTH))
						sp_q <= sp_q + SP_W'(1);
					else
						trap_q <= TRAP_OVERFLOW;
				end
				S_TEER: if (sp_q == '0) trap_q <= TRAP_UNDERFLOW;
				S_TEEW: if (lidx_ok) locals_q[imm_q[LV_W-1:0]] <= st_rdata;
				S_LDW: begin
					val_q[8*k_q +: 8] <= lm_rdata;
					k_q               <= k_q + 2'd1;
				end
				S_LDX: begin
					if (op_q == OP_LOAD8_S)
						res_q <= {{24{val_q[7]}}, val_q[7:0]};
					else if (op_q == OP_LOAD16_S)
						res_q <= {{16{val_q[15]}}, val_q[15:0]};
					else
						res_q <= val_q;
				end
				S_STW: k_q <= k_q + 2'd1;
				S_TOPW: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {6'd0, sp_q, (sp_q != '0) ? st_rdata : 32'd0, trap_q};
					end
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_trap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(trap_q != TRAP_OK && state_q != S_IDLE) |=> (trap_q == $past(trap_q)))
		else $error("pending trap changed while busy");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input taken again before the item finished");
`endif

endmodule

// ===== bench/wasmxu_checker.sv =====
// wasmxu_checker: watches the instruction and result streams of the stack
// execute unit, predicts each result item and compares it; uses wasmxu_pkg
`timescale 1ns / 1ps
module wasmxu_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	output int          outstanding,
	output int          failures
);
	import wasmxu_pkg::*;

	typedef struct {
		trap_t       status;
		logic [31:0] top;
		logic [6:0]  depth;
	} outcome_t;

	outcome_t    expected_q[$];
	logic [31:0] stk[STACK_DEPTH];
	int unsigned sp;
	logic [31:0] locs[NUM_LOCALS];
	logic [31:0] globs[GLOBAL_COUNT];
	logic [7:0]  mem[int unsigned];
	trap_t       trap;
	logic [16:0] mem_limit;

	function automatic bit pop_word(output logic [31:0] v);
		if (sp == 0) begin
			trap = TRAP_UNDERFLOW;
			return 0;
		end
		sp--;
		v = stk[sp];
		return 1;
	endfunction

	function automatic bit push_word(input logic [31:0] v);
		if (sp >= STACK_DEPTH) begin
			trap = TRAP_OVERFLOW;
			return 0;
		end
		stk[sp] = v;
		sp++;
		return 1;
	endfunction

	function automatic bit fits(input logic [31:0] base, input logic [31:0] off, input int w);
		longint unsigned lim, last;
		lim = (mem_limit < MEM_BYTES) ? mem_limit : MEM_BYTES;
		last = longint'(base) + longint'(off) + w;
		if (last > lim) begin
			trap = TRAP_OOB;
			return 0;
		end
		return 1;
	endfunction

	function automatic logic [7:0] rd_byte(input logic [31:0] addr);
		return mem.exists(addr) ? mem[addr] : 8'h00;
	endfunction

	function automatic logic [31:0] mag(input logic [31:0] x);
		return x[31] ? -x : x;
	endfunction

	function automatic logic [31:0] alu(input logic [7:0] op, input logic [31:0] a,
			input logic [31:0] b);
		logic [4:0]  s;
		logic [31:0] q;
		s = b[4:0];
		case (op)
			OP_ADD:   return a + b;
			OP_SUB:   return a - b;
			OP_MUL:   return a * b;
			OP_DIV_S: begin
				q = mag(a) / mag(b);
				return (a[31] ^ b[31]) ? -q : q;
			end
			OP_DIV_U: return a / b;
			OP_REM_S: begin
				q = mag(a) % mag(b);
				return a[31] ? -q : q;
			end
			OP_REM_U: return a % b;
			OP_AND:   return a & b;
			OP_OR:    return a | b;
			OP_XOR:   return a ^ b;
			OP_SHL:   return a << s;
			OP_SHR_S: return $signed(a) >>> s;
			default:  return a >> s;
		endcase
	endfunction

	function automatic bit cmp(input logic [7:0] op, input logic [31:0] a, input logic [31:0] b);
		case (op)
			OP_EQ:   return a == b;
			OP_NE:   return a != b;
			OP_LT_S: return $signed(a) < $signed(b);
			OP_LT_U: return a < b;
			OP_GT_S: return $signed(a) > $signed(b);
			OP_GT_U: return a > b;
			OP_LE_S: return $signed(a) <= $signed(b);
			OP_LE_U: return a <= b;
			OP_GE_S: return $signed(a) >= $signed(b);
			default: return a >= b;
		endcase
	endfunction

	task automatic run_instr(input logic [7:0] op, input logic [31:0] imm, input logic sf);
		logic [31:0] a, b, c, r, addr;
		int          w;
		if (sf) begin
			sp = 0;
			foreach (locs[i]) locs[i] = '0;
			trap = TRAP_OK;
		end
		if (trap != TRAP_OK)
			return;
		case (op)
			OP_TRAP: trap = TRAP_UNREACHABLE;
			OP_NOP: ;
			OP_DROP: void'(pop_word(a));
			OP_SEL: if (pop_word(c) && pop_word(b) && pop_word(a))
				void'(push_word(c != 0 ? a : b));
			OP_LGET: if (imm < NUM_LOCALS)
				void'(push_word(locs[imm[LV_W-1:0]]));
			OP_LSET: if (pop_word(a) && imm < NUM_LOCALS)
				locs[imm[LV_W-1:0]] = a;
			OP_LTEE: begin
				if (sp == 0)
					trap = TRAP_UNDERFLOW;
				else if (imm < NUM_LOCALS)
					locs[imm[LV_W-1:0]] = stk[sp-1];
			end
			OP_GGET: if (imm < GLOBAL_COUNT)
				void'(push_word(globs[imm[GV_W-1:0]]));
			OP_GSET: if (pop_word(a) && imm < GLOBAL_COUNT)
				globs[imm[GV_W-1:0]] = a;
			OP_LOAD, OP_LOAD8_S, OP_LOAD8_U, OP_LOAD16_S, OP_LOAD16_U: begin
				w = (op == OP_LOAD) ? 4 : (op == OP_LOAD8_S || op == OP_LOAD8_U) ? 1 : 2;
				if (pop_word(a) && fits(a, imm, w)) begin
					addr = a + imm;
					r = '0;
					for (int i = 0; i < w; i++)
						r |= 32'(rd_byte(addr + i)) << (8 * i);
					if (op == OP_LOAD8_S && r[7])
						r |= 32'hFFFF_FF00;
					if (op == OP_LOAD16_S && r[15])
						r |= 32'hFFFF_0000;
					void'(push_word(r));
				end
			end
			OP_STORE, OP_STORE8, OP_STORE16: begin
				w = (op == OP_STORE) ? 4 : (op == OP_STORE8) ? 1 : 2;
				if (pop_word(b) && pop_word(a) && fits(a, imm, w))
					for (int i = 0; i < w; i++)
						mem[a + imm + i] = b[8*i +: 8];
			end
			OP_CONST: void'(push_word(imm));
			OP_EQZ: if (pop_word(a))
				void'(push_word(a == 0));
			OP_EQ, OP_NE, OP_LT_S, OP_LT_U, OP_GT_S, OP_GT_U, OP_LE_S, OP_LE_U,
			OP_GE_S, OP_GE_U: if (pop_word(b) && pop_word(a))
				void'(push_word(cmp(op, a, b)));
			OP_ADD, OP_SUB, OP_MUL, OP_DIV_S, OP_DIV_U, OP_REM_S, OP_REM_U, OP_AND,
			OP_OR, OP_XOR, OP_SHL, OP_SHR_S, OP_SHR_U: begin
				if (pop_word(b) && pop_word(a)) begin
					if ((op == OP_DIV_S || op == OP_DIV_U || op == OP_REM_S ||
							op == OP_REM_U) && b == 0)
						trap = TRAP_DIV_ZERO;
					else
						void'(push_word(alu(op, a, b)));
				end
			end
			default: trap = TRAP_BAD_OP;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_item;
		int       errs;
		if (!arst_n) begin
			expected_q.delete();
			mem.delete();
			sp = 0;
			foreach (locs[i]) locs[i] = '0;
			foreach (globs[i]) globs[i] = '0;
			trap = TRAP_OK;
			mem_limit = 17'd65536;
			outstanding <= 0;
			failures <= 0;
		end else begin
			if (cfg_we)
				mem_limit = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				run_instr(s_axis_tdata[7:0], s_axis_tdata[39:8], s_axis_tuser);
				exp_item.status = trap;
				exp_item.top = (sp > 0) ? stk[sp-1] : 32'h0;
				exp_item.depth = sp[6:0];
				expected_q.push_back(exp_item);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					$error("result item with no expectation: %h", m_axis_tdata);
					failures <= failures + 1;
				end else begin
					errs = 0;
					exp_item = expected_q.pop_front();
					if (m_axis_tdata[2:0] != exp_item.status) begin
						$error("status: expected %0d actual %0d", exp_item.status,
							m_axis_tdata[2:0]);
						errs++;
					end
					if (m_axis_tdata[34:3] != exp_item.top) begin
						$error("top_value: expected %h actual %h", exp_item.top,
							m_axis_tdata[34:3]);
						errs++;
					end
					if (m_axis_tdata[41:35] != exp_item.depth) begin
						$error("stack_count: expected %0d actual %0d", exp_item.depth,
							m_axis_tdata[41:35]);
						errs++;
					end
					failures <= failures + errs;
				end
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// tb: stimulus and verdict for wasm_i32_stack_execute_unit; depends on
// wasmxu_pkg, the unit itself and wasmxu_checker for prediction and compare
`timescale 1ns / 1ps
module tb;
	import wasmxu_pkg::*;

	localparam int HI_BASE = 65408;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // op [7:0], imm [39:8]
	logic        s_axis_tuser;   // start_frame
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // status [2:0], top_value [34:3], stack_count [41:35]
	logic        cfg_we;
	logic [16:0] cfg_wdata;
	int          outstanding;
	int          failures;
	int          src_idle;
	int          dst_idle;
	logic        hold;
	int          sent;
	int          settings;

	logic [7:0] bin_ops [0:22] = '{OP_EQ, OP_NE, OP_LT_S, OP_LT_U, OP_GT_S, OP_GT_U,
		OP_LE_S, OP_LE_U, OP_GE_S, OP_GE_U, OP_ADD, OP_SUB, OP_MUL, OP_DIV_S, OP_DIV_U,
		OP_REM_S, OP_REM_U, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR_S, OP_SHR_U};
	logic [7:0] load_ops [0:4] = '{OP_LOAD, OP_LOAD8_S, OP_LOAD8_U, OP_LOAD16_S, OP_LOAD16_U};
	logic [7:0] store_ops [0:2] = '{OP_STORE, OP_STORE8, OP_STORE16};
	logic [16:0] limits [0:6] = '{17'd0, 17'd65536, 17'd1, 17'd130, 17'd4000,
		17'd65535, 17'd65409};

	wasm_i32_stack_execute_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	wasmxu_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.outstanding(outstanding), .failures(failures)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !hold && ($urandom_range(0, 99) >= dst_idle);
		end
	end

	task automatic put(input logic [7:0] op, input logic [31:0] imm, input logic sf);
		while ($urandom_range(0, 99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {imm, op};
		s_axis_tuser <= sf;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	// bases and offsets either inside a written region or beyond all memory
	task automatic pick_addr(input int w, output logic [31:0] base, output logic [31:0] off);
		int addr;
		case ($urandom_range(0, 4))
			0, 1: addr = $urandom_range(0, 128 - w);
			2, 3: addr = HI_BASE + $urandom_range(0, 128 - w);
			default: addr = -1;
		endcase
		if (addr < 0) begin
			base = $urandom | 32'h0001_0000;
			off = $urandom_range(0, 1) ? $urandom : 32'h0;
		end else begin
			off = $urandom_range(0, addr);
			base = addr - off;
		end
	endtask

	task automatic run_sequence();
		logic        sf;
		logic [7:0]  op;
		logic [31:0] base, off;
		int          w;
		sf = ($urandom_range(0, 99) < 12);
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6: begin
				put(OP_CONST, pick_word(), sf);
				put(OP_CONST, pick_word(), 1'b0);
				put(bin_ops[$urandom_range(0, 22)], $urandom, 1'b0);
			end
			7, 8: begin
				put(OP_CONST, pick_word(), sf);
				case ($urandom_range(0, 5))
					0: put(OP_EQZ, $urandom, 1'b0);
					1: put(OP_DROP, $urandom, 1'b0);
					2: put(OP_LSET, $urandom_range(0, 17), 1'b0);
					3: put(OP_LTEE, $urandom_range(0, 17), 1'b0);
					4: put(OP_GSET, $urandom_range(0, 17), 1'b0);
					default: put(OP_CONST, pick_word(), 1'b0);
				endcase
			end
			9: begin
				put(OP_CONST, pick_word(), sf);
				put(OP_CONST, pick_word(), 1'b0);
				put(OP_CONST, $urandom_range(0, 1) ? 32'h0 : pick_word(), 1'b0);
				put(OP_SEL, $urandom, 1'b0);
			end
			10, 11, 12: begin
				op = load_ops[$urandom_range(0, 4)];
				w = (op == OP_LOAD) ? 4 : (op == OP_LOAD8_S || op == OP_LOAD8_U) ? 1 : 2;
				pick_addr(w, base, off);
				put(OP_CONST, base, sf);
				put(op, off, 1'b0);
			end
			13, 14, 15: begin
				op = store_ops[$urandom_range(0, 2)];
				w = (op == OP_STORE) ? 4 : (op == OP_STORE8) ? 1 : 2;
				pick_addr(w, base, off);
				if ($urandom_range(0, 3) == 0)
					base = $urandom;
				put(OP_CONST, base, sf);
				put(OP_CONST, pick_word(), 1'b0);
				put(op, off, 1'b0);
			end
			16, 17: begin
				put($urandom_range(0, 1) ? OP_LGET : OP_GGET,
					$urandom_range(0, 3) ? $urandom_range(0, 17) : $urandom, sf);
			end
			18: put(OP_DROP, $urandom, sf);
			default: begin
				do
					op = 8'($urandom_range(0, 255));
				while (op == OP_LOAD || (op >= OP_LOAD8_S && op <= OP_LOAD16_U));
				put(op, $urandom, sf);
			end
		endcase
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic set_limit(input logic [16:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	initial begin
		int phase_end;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		hold <= 1'b0;
		src_idle = 0;
		dst_idle = 0;
		sent = 0;
		settings = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_limit(17'd65536);
		// fill both ends of memory so later loads only see written bytes
		for (int i = 0; i < 32; i++) begin
			put(OP_CONST, 4 * i, 1'b1);
			put(OP_CONST, $urandom, 1'b0);
			put(OP_STORE, 32'h0, 1'b0);
			put(OP_CONST, HI_BASE, 1'b1);
			put(OP_CONST, $urandom, 1'b0);
			put(OP_STORE, 4 * i, 1'b0);
		end

		// signed overflow cases, divide by zero, bad op, underflow, index range, bounds
		put(OP_CONST, 32'h8000_0000, 1'b1);
		put(OP_CONST, 32'hFFFF_FFFF, 1'b0);
		put(OP_DIV_S, 32'h0, 1'b0);
		put(OP_CONST, 32'h8000_0000, 1'b0);
		put(OP_CONST, 32'hFFFF_FFFF, 1'b0);
		put(OP_REM_S, 32'h0, 1'b0);
		put(OP_CONST, 32'h21, 1'b0);
		put(OP_SHR_S, 32'h0, 1'b0);
		put(OP_CONST, 32'h0, 1'b0);
		put(OP_DIV_U, 32'h0, 1'b0);
		put(OP_TRAP, 32'h0, 1'b1);
		put(8'hFF, 32'hFFFF_FFFF, 1'b1);
		put(OP_DROP, 32'h0, 1'b1);
		put(OP_LTEE, 32'h0, 1'b1);
		put(OP_CONST, 32'h3, 1'b1);
		put(OP_LSET, 32'd16, 1'b0);
		put(OP_LGET, 32'd16, 1'b0);
		put(OP_CONST, 32'h5A5A_0001, 1'b0);
		put(OP_GSET, 32'd15, 1'b0);
		put(OP_GGET, 32'd15, 1'b0);
		put(OP_CONST, 32'd65535, 1'b1);
		put(OP_LOAD8_U, 32'h0, 1'b0);
		put(OP_CONST, 32'hFFFF_FFFF, 1'b0);
		put(OP_LOAD, 32'hFFFF_FFFF, 1'b0);
		drain();

		for (int p = 0; p < 7; p++) begin
			set_limit(p == 6 ? 17'($urandom_range(0, 65536)) : limits[p]);
			src_idle = (p < 2) ? 6 : (p < 4) ? 56 : 0;
			dst_idle = (p < 2) ? 56 : (p < 4) ? 6 : 0;
			if (p == 4)
				fork
					begin
						hold <= 1'b1;
						repeat (400) @(posedge clk);
						hold <= 1'b0;
					end
				join_none
			phase_end = sent + 220;
			while (sent < phase_end)
				run_sequence();
			drain();
		end

		$display("%0d instructions sent over %0d memory size settings,", sent, settings);
		$display("with idle and stall patterns on both streams and a long output hold-off");
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/wasmxu_pkg.sv
hdl/wasmxu_div.sv
hdl/wasm_i32_stack_execute_unit.sv
bench/wasmxu_checker.sv
bench/tb.sv
